// ===== rtl/vtp_pkg.sv =====
// Shared constants, control word layout and microcode table for the vertex transform.
`timescale 1ns / 1ps

package vtp_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int DATA_W     = 32;
   localparam int IDX_W      = 4;
   localparam int ACC_W      = 2 * DATA_W - FRAC_BITS + 2;
   localparam int DIV_SHIFT  = DATA_W - FRAC_BITS;
   localparam int CNT_W      = $clog2(DATA_W);
   localparam int STEP_W     = 5;
   localparam int REQ_DATA_W = ((IDX_W + 4 * DATA_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = 3 * DATA_W;

   localparam logic signed [DATA_W-1:0] ONE_FX = DATA_W'(1) << FRAC_BITS;
   localparam logic [DATA_W-1:0] SAT_POS = {1'b0, {(DATA_W - 1){1'b1}}};
   localparam logic [DATA_W-1:0] SAT_NEG = {1'b1, {(DATA_W - 1){1'b0}}};

   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_XFORM = 1'b1;

   localparam logic [1:0] XS_X   = 2'd0;
   localparam logic [1:0] XS_Y   = 2'd1;
   localparam logic [1:0] XS_Z   = 2'd2;
   localparam logic [1:0] XS_ONE = 2'd3;

   localparam logic [1:0] ACC_NOP = 2'd0;
   localparam logic [1:0] ACC_SET = 2'd1;
   localparam logic [1:0] ACC_ADD = 2'd2;

   localparam logic [1:0] ST_NONE = 2'd0;
   localparam logic [1:0] ST_X    = 2'd1;
   localparam logic [1:0] ST_Y    = 2'd2;

   localparam logic [1:0] J_NEXT = 2'd0;
   localparam logic [1:0] J_BUSY = 2'd1;
   localparam logic [1:0] J_END  = 2'd2;

   typedef struct packed {
      logic              ld;
      logic [IDX_W-1:0]  csel;
      logic [1:0]        xsel;
      logic              mul;
      logic [1:0]        acc;
      logic              wlat;
      logic              dstart;
      logic [1:0]        store;
      logic [1:0]        jcond;
      logic [STEP_W-1:0] jtgt;
   } ctrl_word_type;

   typedef struct packed {
      logic div_busy;
      logic out_block;
   } seq_status_type;

   typedef struct packed {
      logic [DATA_W-1:0] q;
      logic              ovf;
      logic              wz;
   } div_result_type;

   localparam ctrl_word_type CW_NOP = '{
      ld: 1'b0, csel: '0, xsel: XS_X, mul: 1'b0, acc: ACC_NOP, wlat: 1'b0,
      dstart: 1'b0, store: ST_NONE, jcond: J_NEXT, jtgt: '0};

   // One dot product: four operand loads, four multiplies, four accumulates.
   function automatic ctrl_word_type dot_word(input logic [1:0] row, input logic [2:0] off);
      ctrl_word_type w;
      w = CW_NOP;
      if (off <= 3'd3) begin
         w.ld   = 1'b1;
         w.csel = {off[1:0], row};
         case (off[1:0])
            2'd0:    w.xsel = XS_X;
            2'd1:    w.xsel = XS_Y;
            2'd2:    w.xsel = XS_Z;
            default: w.xsel = XS_ONE;
         endcase
      end
      w.mul = (off >= 3'd1) && (off <= 3'd4);
      if (off == 3'd2) begin
         w.acc = ACC_SET;
      end else if (off >= 3'd3 && off <= 3'd5) begin
         w.acc = ACC_ADD;
      end
      return w;
   endfunction

   function automatic ctrl_word_type ucode(input logic [STEP_W-1:0] step);
      ctrl_word_type     w;
      logic [STEP_W-1:0] rel;
      w   = CW_NOP;
      rel = '0;
      case (step) inside
         [5'd0:5'd5]: begin
            rel = step;
            w   = dot_word(2'd3, rel[2:0]);
         end
         5'd6: begin
            w.wlat = 1'b1;
         end
         [5'd7:5'd12]: begin
            rel = step - 5'd7;
            w   = dot_word(2'd0, rel[2:0]);
         end
         5'd13: begin
            w.dstart = 1'b1;
         end
         [5'd14:5'd19]: begin
            rel = step - 5'd14;
            w   = dot_word(2'd1, rel[2:0]);
         end
         5'd20, 5'd28, 5'd30: begin
            w.jcond = J_BUSY;
            w.jtgt  = step;
         end
         5'd21: begin
            w.store  = ST_X;
            w.dstart = 1'b1;
         end
         [5'd22:5'd27]: begin
            rel = step - 5'd22;
            w   = dot_word(2'd2, rel[2:0]);
         end
         5'd29: begin
            w.store  = ST_Y;
            w.dstart = 1'b1;
         end
         5'd31: begin
            w.jcond = J_END;
         end
         default: begin
            w = CW_NOP;
         end
      endcase
      return w;
   endfunction

endpackage

// ===== rtl/vtp_sequencer.sv =====
// Step counter and microcode read-out with conditional jumps.
`timescale 1ns / 1ps

module vtp_sequencer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  vtp_pkg::seq_status_type status,
   output vtp_pkg::ctrl_word_type ctrl,
   output logic                   run,
   output logic                   done
);

   logic                           run_ff, run_in;
   logic [vtp_pkg::STEP_W-1:0]     step_ff, step_in;
   vtp_pkg::ctrl_word_type         word;

   always_comb begin
      word    = vtp_pkg::ucode(step_ff);
      run_in  = run_ff;
      step_in = step_ff;
      done    = 1'b0;
      if (!run_ff) begin
         if (start) begin
            run_in  = 1'b1;
            step_in = '0;
         end
      end else begin
         case (word.jcond)
            vtp_pkg::J_BUSY: begin
               step_in = status.div_busy ? word.jtgt : step_ff + vtp_pkg::STEP_W'(1);
            end
            vtp_pkg::J_END: begin
               if (!status.out_block) begin
                  run_in  = 1'b0;
                  step_in = '0;
                  done    = 1'b1;
               end
            end
            default: begin
               step_in = step_ff + vtp_pkg::STEP_W'(1);
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         step_ff <= '0;
      end else begin
         run_ff  <= run_in;
         step_ff <= step_in;
      end
   end

   assign ctrl = run_ff ? word : vtp_pkg::CW_NOP;
   assign run  = run_ff;

endmodule

// ===== rtl/vtp_datapath.sv =====
// Matrix store, operand registers, shared multiplier and accumulator.
`timescale 1ns / 1ps

module vtp_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  vtp_pkg::ctrl_word_type            ctrl,
   input  logic                              load_en,
   input  logic [vtp_pkg::IDX_W-1:0]         load_idx,
   input  logic signed [vtp_pkg::DATA_W-1:0] load_val,
   input  logic                              point_en,
   input  logic signed [vtp_pkg::DATA_W-1:0] point_x,
   input  logic signed [vtp_pkg::DATA_W-1:0] point_y,
   input  logic signed [vtp_pkg::DATA_W-1:0] point_z,
   output logic signed [vtp_pkg::ACC_W-1:0]  acc,
   output logic signed [vtp_pkg::ACC_W-1:0]  w
);

   logic signed [vtp_pkg::DATA_W-1:0]   matrix_ff [16];
   logic signed [vtp_pkg::DATA_W-1:0]   x_ff, y_ff, z_ff;
   logic signed [vtp_pkg::DATA_W-1:0]   opa_ff, opb_ff, opb_in;
   logic signed [2*vtp_pkg::DATA_W-1:0] prod_ff, prod_shr;
   logic signed [vtp_pkg::ACC_W-1:0]    acc_ff, acc_in, term;
   logic signed [vtp_pkg::ACC_W-1:0]    w_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 16; i++) begin
            matrix_ff[i] <= (i % 5 == 0) ? vtp_pkg::ONE_FX : '0;
         end
      end else if (load_en) begin
         matrix_ff[load_idx] <= load_val;
      end
   end

   always_comb begin
      case (ctrl.xsel)
         vtp_pkg::XS_X: opb_in = x_ff;
         vtp_pkg::XS_Y: opb_in = y_ff;
         vtp_pkg::XS_Z: opb_in = z_ff;
         default:       opb_in = vtp_pkg::ONE_FX;
      endcase
      prod_shr = prod_ff >>> vtp_pkg::FRAC_BITS;
      term     = prod_shr[vtp_pkg::ACC_W-1:0];
      case (ctrl.acc)
         vtp_pkg::ACC_SET: acc_in = term;
         vtp_pkg::ACC_ADD: acc_in = acc_ff + term;
         default:          acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (point_en) begin
         x_ff <= point_x;
         y_ff <= point_y;
         z_ff <= point_z;
      end
      if (ctrl.ld) begin
         opa_ff <= matrix_ff[ctrl.csel];
         opb_ff <= opb_in;
      end
      if (ctrl.mul) begin
         prod_ff <= opa_ff * opb_ff;
      end
      acc_ff <= acc_in;
      if (ctrl.wlat) begin
         w_ff <= acc_ff;
      end
   end

   assign acc = acc_ff;
   assign w   = w_ff;

endmodule

// ===== rtl/vtp_divider.sv =====
// Radix-2 restoring divider with perspective saturation rules.
`timescale 1ns / 1ps

module vtp_divider (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic signed [vtp_pkg::ACC_W-1:0] num,
   input  logic signed [vtp_pkg::ACC_W-1:0] den,
   output logic                             busy,
   output vtp_pkg::div_result_type          res
);

   localparam int AW = vtp_pkg::ACC_W;
   localparam int DW = vtp_pkg::DATA_W;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_CHECK = 2'd1;
   localparam logic [1:0] S_ITER  = 2'd2;

   logic [1:0]                     state_ff, state_in;
   logic [vtp_pkg::CNT_W-1:0]      cnt_ff, cnt_in;
   logic [AW-1:0]                  n_ff, d_ff, r_ff, r_in;
   logic [DW-1:0]                  sh_ff, sh_in, quo;
   logic                           num_neg_ff, neg_ff;
   logic [AW:0]                    r2, diff;
   logic                           ge, res_we;
   vtp_pkg::div_result_type        res_ff, res_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      r_in     = r_ff;
      sh_in    = sh_ff;
      res_we   = 1'b0;
      res_in   = res_ff;
      r2       = {r_ff, sh_ff[DW-1]};
      diff     = r2 - {1'b0, d_ff};
      ge       = r2 >= {1'b0, d_ff};
      quo      = {sh_ff[DW-2:0], ge};
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            res_we = 1'b1;
            res_in.wz  = 1'b0;
            res_in.ovf = 1'b0;
            if (d_ff == '0) begin
               state_in  = S_IDLE;
               res_in.wz = 1'b1;
               if (n_ff == '0) begin
                  res_in.q = '0;
               end else begin
                  res_in.q = num_neg_ff ? vtp_pkg::SAT_NEG : vtp_pkg::SAT_POS;
               end
            end else if ({{vtp_pkg::DIV_SHIFT{1'b0}}, n_ff} >=
                         {d_ff, {vtp_pkg::DIV_SHIFT{1'b0}}}) begin
               state_in   = S_IDLE;
               res_in.ovf = 1'b1;
               res_in.q   = neg_ff ? vtp_pkg::SAT_NEG : vtp_pkg::SAT_POS;
            end else begin
               res_we   = 1'b0;
               state_in = S_ITER;
               cnt_in   = vtp_pkg::CNT_W'(DW - 1);
               r_in     = {{vtp_pkg::DIV_SHIFT{1'b0}}, n_ff[AW-1:vtp_pkg::DIV_SHIFT]};
               sh_in    = {n_ff[vtp_pkg::DIV_SHIFT-1:0], {vtp_pkg::FRAC_BITS{1'b0}}};
            end
         end
         S_ITER: begin
            r_in   = ge ? diff[AW-1:0] : r2[AW-1:0];
            sh_in  = quo;
            cnt_in = cnt_ff - vtp_pkg::CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in   = S_IDLE;
               res_we     = 1'b1;
               res_in.wz  = 1'b0;
               res_in.ovf = 1'b0;
               if (neg_ff) begin
                  if (quo > vtp_pkg::SAT_NEG) begin
                     res_in.ovf = 1'b1;
                     res_in.q   = vtp_pkg::SAT_NEG;
                  end else begin
                     res_in.q = ~quo + DW'(1);
                  end
               end else if (quo[DW-1]) begin
                  res_in.ovf = 1'b1;
                  res_in.q   = vtp_pkg::SAT_POS;
               end else begin
                  res_in.q = quo;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         res_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (res_we) begin
            res_ff <= res_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && start) begin
         n_ff       <= num[AW-1] ? AW'(-num) : num;
         d_ff       <= den[AW-1] ? AW'(-den) : den;
         num_neg_ff <= num[AW-1];
         neg_ff     <= num[AW-1] ^ den[AW-1];
      end
      cnt_ff <= cnt_in;
      r_ff   <= r_in;
      sh_ff  <= sh_in;
   end

   assign busy = (state_ff != S_IDLE);
   assign res  = res_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> state_ff == S_IDLE)
      else $error("division started while divider busy");

   a_zero_w: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK && d_ff == '0) |=> (state_ff == S_IDLE && res_ff.wz && !res_ff.ovf))
      else $error("zero divisor not flagged as w_zero");

   a_hold_res: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && !start) |=> $stable(res_ff))
      else $error("quotient changed while divider idle");

endmodule

// ===== rtl/vertex_transform_perspective.sv =====
// Top level: request and response channels around the microcoded vertex transform.
`timescale 1ns / 1ps

// A load request (tuser 0) writes one Q16.16 coefficient of the column-major 4x4 matrix
// when it is taken and gives no response; the matrix resets to identity. A transform request
// (tuser 1) runs a 32-step microprogram: sixteen multiply-accumulates on one 32x32
// multiplier form w and the three numerators, and one shared radix-2 divider forms the
// three quotients, one quotient bit per cycle. The input stays closed while the
// microprogram runs, and the sequencer waits on each of the three divider passes (a check
// state, then 32 quotient bits); a zero w or an out-of-range quotient ends a pass after
// the check state. A finished response waits in an output register, and the next request
// is taken while it waits; a second transform then holds at its last step until it drains.
module vertex_transform_perspective (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // coef_index, coef_value, point_x, point_y, point_z, zero pad
   input  logic [vtp_pkg::REQ_DATA_W-1:0]     req_tdata,
   // func
   input  logic [0:0]                         req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // out_x, out_y, out_z
   output logic [vtp_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // w_zero, overflowed
   output logic [1:0]                         rsp_tuser
);

   localparam int   DW         = vtp_pkg::DATA_W;
   localparam int   IW         = vtp_pkg::IDX_W;

   logic                             req_take, load_en, xform_start, seq_run, seq_done;
   vtp_pkg::ctrl_word_type           ctrl;
   vtp_pkg::seq_status_type          status;
   vtp_pkg::div_result_type          div_res;
   logic                             div_busy;
   logic signed [vtp_pkg::ACC_W-1:0] acc, w;
   logic [DW-1:0]                    res_x_ff, res_y_ff;
   logic                             ovf_ff, ovf_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [vtp_pkg::RSP_DATA_W-1:0]   rsp_data_ff;
   logic [1:0]                       rsp_user_ff;

   assign req_tready  = !seq_run;
   assign req_take    = req_tvalid && req_tready;
   assign load_en     = req_take && (req_tuser[0] == vtp_pkg::FUNC_LOAD);
   assign xform_start = req_take && (req_tuser[0] == vtp_pkg::FUNC_XFORM);

   assign status.div_busy  = div_busy;
   assign status.out_block = rsp_valid_ff && !rsp_tready;

   vtp_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .start  (xform_start),
      .status (status),
      .ctrl   (ctrl),
      .run    (seq_run),
      .done   (seq_done)
   );

   vtp_datapath u_dp (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .load_en  (load_en),
      .load_idx (req_tdata[IW-1:0]),
      .load_val (req_tdata[IW+DW-1:IW]),
      .point_en (xform_start),
      .point_x  (req_tdata[IW+2*DW-1:IW+DW]),
      .point_y  (req_tdata[IW+3*DW-1:IW+2*DW]),
      .point_z  (req_tdata[IW+4*DW-1:IW+3*DW]),
      .acc      (acc),
      .w        (w)
   );

   vtp_divider u_div (
      .clock (clock),
      .reset (reset),
      .start (ctrl.dstart),
      .num   (acc),
      .den   (w),
      .busy  (div_busy),
      .res   (div_res)
   );

   always_comb begin
      ovf_in = ovf_ff;
      if (xform_start) begin
         ovf_in = 1'b0;
      end else if (ctrl.store != vtp_pkg::ST_NONE) begin
         ovf_in = ovf_ff | div_res.ovf;
      end
      rsp_valid_in = rsp_valid_ff;
      if (seq_done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         ovf_ff       <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         ovf_ff       <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.store == vtp_pkg::ST_X) begin
         res_x_ff <= div_res.q;
      end
      if (ctrl.store == vtp_pkg::ST_Y) begin
         res_y_ff <= div_res.q;
      end
      if (seq_done) begin
         rsp_data_ff <= {div_res.q, res_y_ff, res_x_ff};
         rsp_user_ff <= {ovf_ff | div_res.ovf, div_res.wz};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule
